### hdl/fcou_pkg.sv
// Package with types, constants and rounding helpers for the fly camera core.
`default_nettype none
package fcou_pkg;

  // Request kinds carried in the input tuser.
  typedef enum logic [1:0] {
    REQ_MOVE    = 2'd0,
    REQ_LOOK    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // Move directions.
  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_LOOK_GAIN   = 3'd1;
  localparam logic [2:0] CFG_PITCH_LIMIT = 3'd2;
  localparam logic [2:0] CFG_START_X     = 3'd3;
  localparam logic [2:0] CFG_START_Y     = 3'd4;
  localparam logic [2:0] CFG_START_Z     = 3'd5;

  // Angles in Q16.16 degrees.
  localparam logic signed [31:0] DEG_90   = 32'sd5898240;
  localparam logic signed [31:0] DEG_180  = 32'sd11796480;
  localparam logic signed [33:0] DEG_360  = 34'sd23592960;
  localparam logic signed [31:0] YAW_INIT = -32'sd5898240;

  // Gain-corrected unit start of the rotation, Q2.30.
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [15:0] ONE14     = 16'sd16384;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_MV_VEL, ST_MV_MUL, ST_MV_ACC, ST_LK_YMUL, ST_LK_PMUL,
    ST_LK_PCLAMP, ST_LK_WRAP, ST_LK_FOLD, ST_LK_CORD, ST_LK_CEND,
    ST_LK_VEC0, ST_LK_PROD, ST_DONE
  } state_t;

  // Arctangent of 2^-i in Q16.16 degrees.
  function automatic logic signed [31:0] atan_val(input logic [3:0] i);
    logic signed [31:0] r;
    case (i)
      4'd0:    r = 32'sd2949120;
      4'd1:    r = 32'sd1740967;
      4'd2:    r = 32'sd919879;
      4'd3:    r = 32'sd466945;
      4'd4:    r = 32'sd234379;
      4'd5:    r = 32'sd117304;
      4'd6:    r = 32'sd58666;
      4'd7:    r = 32'sd29335;
      4'd8:    r = 32'sd14668;
      4'd9:    r = 32'sd7334;
      4'd10:   r = 32'sd3667;
      4'd11:   r = 32'sd1833;
      4'd12:   r = 32'sd917;
      4'd13:   r = 32'sd458;
      4'd14:   r = 32'sd229;
      default: r = 32'sd115;
    endcase
    return r;
  endfunction

  // Round half up from Q2.30 to Q2.14 and clamp to plus or minus one.
  function automatic logic signed [15:0] rnd16(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) r = 34'sd16384;
    else if (r < -34'sd16384) r = -34'sd16384;
    return r[15:0];
  endfunction

  // Round half up from a Q4.60 product to Q2.14 and clamp.
  function automatic logic signed [15:0] rnd46(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = (v + 66'sh2000_0000_0000) >>> 46;
    if (r > 66'sd16384) r = 66'sd16384;
    else if (r < -66'sd16384) r = -66'sd16384;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

### hdl/fly_camera_orientation_update_core.sv
// Top level of the fixed-point free-fly camera core.
`default_nettype none
// One word in gives one word out: the position and the front, right and up
// vectors after the request. In a look, the yaw wrap adds or takes off one
// turn at a time until the yaw lies within one turn, so the look time varies.
// Beyond that, the look time is set by the shared
// shift-and-add rotation unit, which runs 16 steps for yaw and again for pitch,
// followed by the shared 33x33 multiplier forming the four cross products. The
// input is not ready while a request is at work; the result sits in an output
// register, so the next word is taken as soon as the sequencer returns to idle.
module fly_camera_orientation_update_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // direction[1:0], delta_time[17:2], x_offset[33:18], y_offset[49:34]
  input  wire logic [55:0]  s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, pos_z (32 each), front_x..z, right_x..z, up_x..z (16 each)
  output logic [239:0]      m_tdata,
  input  wire logic         wr_en,
  input  wire logic [2:0]   wr_index,
  input  wire logic [31:0]  wr_data
);
  import fcou_pkg::*;

  state_t state, state_next;

  logic [15:0] move_speed, look_gain;
  logic [14:0] pitch_limit;
  logic signed [31:0] start_x, start_y, start_z;

  logic [1:0] dir;
  logic [15:0] dt;
  logic signed [15:0] xo, yo;
  logic [1:0] idx;
  logic [3:0] it;
  logic sel, neg;
  logic [31:0] vel;
  logic signed [65:0] prod;
  logic signed [33:0] t;
  logic signed [31:0] yaw, pitch;
  logic signed [33:0] x, y;
  logic signed [31:0] z;
  logic signed [33:0] cy, sy, cp, sp;
  logic signed [31:0] pos [3];
  logic signed [15:0] fv [3];
  logic signed [15:0] rv [3];
  logic signed [15:0] uv [3];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic accept;
  logic out_free;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Shared multiplier.
  assign mul_p = mul_a * mul_b;

  // Datapath helpers.
  logic signed [15:0] comp;
  logic signed [33:0] step, psum, pstep, pclamp, lim, xs, ys, nx, ny, afold;
  logic signed [31:0] ang;
  logic sub;

  always_comb begin
    comp  = (dir == DIR_FORWARD || dir == DIR_BACKWARD) ? fv[idx] : rv[idx];
    sub   = (dir == DIR_BACKWARD || dir == DIR_LEFT);
    step  = 34'((prod + 66'sd2097152) >>> 22);
    psum  = sub ? (34'(pos[idx]) - step) : (34'(pos[idx]) + step);
    pstep = 34'(prod >>> 4);
    lim   = {11'b0, pitch_limit, 8'b0};
    pclamp = 34'(pitch) + pstep;
    if (pclamp > lim) pclamp = lim;
    else if (pclamp < -lim) pclamp = -lim;
    xs    = x >>> it;
    ys    = y >>> it;
    nx    = neg ? -x : x;
    ny    = neg ? -y : y;
    ang   = sel ? pitch : yaw;
    afold = 34'(ang);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state)
      ST_MV_VEL: begin
        mul_a = {17'b0, move_speed};
        mul_b = {17'b0, dt};
      end
      ST_MV_MUL: begin
        mul_a = 33'(comp);
        mul_b = {1'b0, vel};
      end
      ST_LK_YMUL: begin
        mul_a = 33'(xo);
        mul_b = {17'b0, look_gain};
      end
      ST_LK_PMUL: begin
        mul_a = 33'(yo);
        mul_b = {17'b0, look_gain};
      end
      ST_LK_VEC0: begin
        mul_a = cy[32:0];
        mul_b = cp[32:0];
      end
      ST_LK_PROD: begin
        case (idx)
          2'd0: begin
            mul_a = sy[32:0];
            mul_b = cp[32:0];
          end
          2'd1: begin
            mul_a = cy[32:0];
            mul_b = sp[32:0];
          end
          2'd2: begin
            mul_a = sy[32:0];
            mul_b = sp[32:0];
          end
          default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
          end
        endcase
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(s_tuser))
            REQ_MOVE: state_next = ST_MV_VEL;
            REQ_LOOK: state_next = ST_LK_YMUL;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_MV_VEL:    state_next = ST_MV_MUL;
      ST_MV_MUL:    state_next = ST_MV_ACC;
      ST_MV_ACC:    state_next = (idx == 2'd2) ? ST_DONE : ST_MV_MUL;
      ST_LK_YMUL:   state_next = ST_LK_PMUL;
      ST_LK_PMUL:   state_next = ST_LK_PCLAMP;
      ST_LK_PCLAMP: state_next = ST_LK_WRAP;
      ST_LK_WRAP: begin
        if (!t[33] && t < DEG_360) state_next = ST_LK_FOLD;
      end
      ST_LK_FOLD:   state_next = ST_LK_CORD;
      ST_LK_CORD:   state_next = (it == 4'd15) ? ST_LK_CEND : ST_LK_CORD;
      ST_LK_CEND:   state_next = sel ? ST_LK_VEC0 : ST_LK_FOLD;
      ST_LK_VEC0:   state_next = ST_LK_PROD;
      ST_LK_PROD:   state_next = (idx == 2'd3) ? ST_DONE : ST_LK_PROD;
      ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed  <= 16'd640;
      look_gain   <= 16'd6554;
      pitch_limit <= 15'd22784;
      start_x     <= 32'sd0;
      start_y     <= 32'sd0;
      start_z     <= 32'sd0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MOVE_SPEED:  move_speed  <= wr_data[15:0];
        CFG_LOOK_GAIN:   look_gain   <= wr_data[15:0];
        CFG_PITCH_LIMIT: pitch_limit <= wr_data[14:0];
        CFG_START_X:     start_x     <= wr_data;
        CFG_START_Y:     start_y     <= wr_data;
        CFG_START_Z:     start_z     <= wr_data;
        default: ;
      endcase
    end
  end

  // Camera state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw   <= YAW_INIT;
      pitch <= 32'sd0;
      for (int i = 0; i < 3; i++) pos[i] <= 32'sd0;
      fv[0] <= 16'sd0; fv[1] <= 16'sd0; fv[2] <= -ONE14;
      rv[0] <= ONE14;  rv[1] <= 16'sd0; rv[2] <= 16'sd0;
      uv[0] <= 16'sd0; uv[1] <= ONE14;  uv[2] <= 16'sd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            dir <= s_tdata[1:0];
            dt  <= s_tdata[17:2];
            xo  <= s_tdata[33:18];
            yo  <= s_tdata[49:34];
            idx <= 2'd0;
            sel <= 1'b0;
            if (req_t'(s_tuser) == REQ_RESTART) begin
              pos[0] <= start_x;
              pos[1] <= start_y;
              pos[2] <= start_z;
              yaw    <= YAW_INIT;
              pitch  <= 32'sd0;
              fv[0] <= 16'sd0; fv[1] <= 16'sd0; fv[2] <= -ONE14;
              rv[0] <= ONE14;  rv[1] <= 16'sd0; rv[2] <= 16'sd0;
              uv[0] <= 16'sd0; uv[1] <= ONE14;  uv[2] <= 16'sd0;
            end
          end
        end
        ST_MV_VEL: vel <= mul_p[31:0];
        ST_MV_MUL: prod <= mul_p;
        ST_MV_ACC: begin
          // Saturate each coordinate to the signed 32-bit range.
          if (psum > 34'sd2147483647) pos[idx] <= 32'sh7fff_ffff;
          else if (psum < -34'sd2147483648) pos[idx] <= 32'sh8000_0000;
          else pos[idx] <= psum[31:0];
          idx <= idx + 2'd1;
        end
        ST_LK_YMUL: prod <= mul_p;
        ST_LK_PMUL: begin
          t    <= 34'(yaw) + pstep + 34'(DEG_180);
          prod <= mul_p;
        end
        ST_LK_PCLAMP: pitch <= pclamp[31:0];
        ST_LK_WRAP: begin
          // Bring the shifted yaw into one turn, one turn per cycle.
          if (t[33]) t <= t + DEG_360;
          else if (t >= DEG_360) t <= t - DEG_360;
          else yaw <= t[31:0] - DEG_180;
        end
        ST_LK_FOLD: begin
          x  <= CORDIC_X0;
          y  <= 34'sd0;
          it <= 4'd0;
          if (afold > 34'(DEG_90)) begin
            z   <= ang - DEG_180;
            neg <= 1'b1;
          end else if (afold < -34'(DEG_90)) begin
            z   <= ang + DEG_180;
            neg <= 1'b1;
          end else begin
            z   <= ang;
            neg <= 1'b0;
          end
        end
        ST_LK_CORD: begin
          // One rotation step toward zero residual angle.
          if (!z[31]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_val(it);
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_val(it);
          end
          it <= it + 4'd1;
        end
        ST_LK_CEND: begin
          if (!sel) begin
            cy  <= nx;
            sy  <= ny;
            sel <= 1'b1;
          end else begin
            cp <= nx;
            sp <= ny;
          end
        end
        ST_LK_VEC0: begin
          // Vector parts that need no product; the sign follows cos pitch.
          fv[1] <= rnd16(sp);
          rv[0] <= cp[33] ? rnd16(sy) : rnd16(-sy);
          rv[1] <= 16'sd0;
          rv[2] <= cp[33] ? rnd16(-cy) : rnd16(cy);
          uv[1] <= rnd16(cp[33] ? -cp : cp);
          prod  <= mul_p;
          idx   <= 2'd0;
        end
        ST_LK_PROD: begin
          case (idx)
            2'd0:    fv[0] <= rnd46(prod);
            2'd1:    fv[2] <= rnd46(prod);
            2'd2:    uv[0] <= rnd46(cp[33] ? prod : -prod);
            default: uv[2] <= rnd46(cp[33] ? prod : -prod);
          endcase
          prod <= mul_p;
          idx  <= idx + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {uv[2], uv[1], uv[0], rv[2], rv[1], rv[0],
                   fv[2], fv[1], fv[0], pos[2], pos[1], pos[0]};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### hdl/fcou_chk.sv
// Port checker for the fly camera core, bound to the top level.
`default_nettype none
module fcou_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [239:0] m_tdata
);

  // A held result word stays valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result word dropped");

  // A held result word keeps its data.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result word changed");

  // The core is busy in the cycle after it takes a word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second word taken at once");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result valid after reset");

  // The right vector never leaves the horizontal plane.
  a_right_flat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[175:160] == 16'd0) else $error("right vector tilted");

endmodule

bind fly_camera_orientation_update_core fcou_chk u_fcou_chk (.*);
`default_nettype wire
